// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define XPCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define XPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/xpcr_pkg.sv =====
package xpcr_pkg;

  localparam int NUM_W = 12;
  localparam int CNT_W = 13;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_PARITY = 2'd1,
    OP_CHECK  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [CFG_AW-1:0] CFG_TOTAL  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GSIZE  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_CWORDS = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] seq_or_group;
    logic [9:0]  word_index;
    logic [63:0] word_value;
    logic        last_word;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [12:0] missing_chunks;
    logic [11:0] missing_seq;
    logic        recovered;
    logic [63:0] read_value;
    logic [12:0] received_total;
    logic [12:0] recovered_total;
    logic        all_done;
  } out_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic div;
    logic mul;
    logic sinit;
    logic look;
    logic scan;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_done;
    logic hit;
    logic div_done;
    logic grp_ok;
    logic scan_done;
  } sts_t;

endpackage

// ===== rtl/core/xpcr_ctrl.sv =====
module xpcr_ctrl
  import xpcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       out_free,
  input  sts_t       sts,
  output logic       in_stall,
  output cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_SINIT = 9'b000010000,
    S_LOOK  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_EXEC  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (op_t'(in_op))
            OP_DATA:   state_nxt = S_DIV;
            OP_PARITY: state_nxt = S_MUL;
            OP_CHECK:  state_nxt = S_MUL;
            OP_READ:   state_nxt = S_LOOK;
          endcase
        end
      end
      S_DIV: begin
        if (sts.hit) begin
          state_nxt = S_LOOK;
        end else begin
          cmd.div = 1'b1;
          if (sts.div_done) state_nxt = S_LOOK;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = (sts.op == OP_PARITY) ? S_LOOK : S_SINIT;
      end
      S_SINIT: begin
        cmd.sinit = 1'b1;
        state_nxt = sts.grp_ok ? S_SCAN : S_EXEC;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/core/xpcr_dp.sv =====
`include "assert_macros.svh"

module xpcr_dp
  import xpcr_pkg::*;
#(
  parameter int MAX_CHUNKS = 4096,
  parameter int MAX_GROUPS = 64,
  parameter int MAX_WORDS  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  in_t         in_item,
  input  logic        cfg_we,
  input  logic [12:0] tc_eff,
  input  logic [12:0] gs_eff,
  input  logic [10:0] cwords,
  output out_t        res
);

  localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int XW    = GW + WW;
  localparam int CLR_W = (CW > XW) ? CW : XW;

  // item
  in_t         it_r;
  logic [11:0] num;
  logic [9:0]  w;
  logic        wok, grp_in, w_in;

  // divider and quotient cache
  logic [12:0] rem_r;
  logic [11:0] dq_r, q_r, cache_num_r;
  logic [3:0]  dcnt_r;
  logic        cache_v_r;
  logic [13:0] trial;
  logic        qbit;
  logic        div_done;

  // group bounds and bitmap scan
  logic [24:0] prod_r;
  logic        grp_ok;
  logic [13:0] gend;
  logic [12:0] s_r, end_r, cnt_r, first_r, pend_s_r;
  logic        pend_r, issue;

  // stores
  logic [CLR_W-1:0] clr_r;
  logic             rmap [2**CW];
  logic [63:0]      xmem [2**XW];
  logic             ps_mem [2**GW];
  logic             rmap_rd_r;
  logic [63:0]      xor_rd_r;
  logic             ps_rd_r;
  logic [CW-1:0]    map_raddr, map_waddr;
  logic [XW-1:0]    xaddr, x_waddr;
  logic             map_we, map_wd, x_we;
  logic [63:0]      x_wd;
  logic [GW-1:0]    gidx;

  // running state
  logic        da_r, pa_r, da_nxt, pa_nxt;
  logic [12:0] rc_r, recc_r, rc_nxt, recc_nxt;
  logic        ps_set;
  out_t        res_nxt;
  out_t        res_r;

  assign num    = it_r.seq_or_group;
  assign w      = it_r.word_index;
  assign w_in   = 32'(w) < MAX_WORDS;
  assign wok    = ({1'b0, w} < cwords) && w_in;
  assign grp_in = 32'(num) < MAX_GROUPS;
  assign gidx   = GW'(num);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else if (cmd.load) begin
      it_r <= in_item;
    end
  end

  // restoring divide of the sequence number by the group size, one bit a cycle
  assign trial    = {rem_r, dq_r[11]};
  assign qbit     = (trial >= {1'b0, gs_eff});
  assign div_done = (dcnt_r == 4'(NUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= '0;
      dq_r   <= in_item.seq_or_group;
      dcnt_r <= '0;
    end else if (cmd.div) begin
      rem_r  <= qbit ? 13'(trial - {1'b0, gs_eff}) : trial[12:0];
      dq_r   <= {dq_r[10:0], qbit};
      dcnt_r <= dcnt_r + 4'd1;
    end
    if (cmd.div && div_done) begin
      q_r         <= {dq_r[10:0], qbit};
      cache_num_r <= num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_v_r <= 1'b0;
    end else if (cfg_we) begin
      cache_v_r <= 1'b0;
    end else if (cmd.div && div_done) begin
      cache_v_r <= 1'b1;
    end
  end

  // group start = group * size; valid iff start below total and group below MAX_GROUPS
  assign grp_ok = (prod_r < 25'(tc_eff)) && grp_in;
  assign gend   = {1'b0, prod_r[12:0]} + {1'b0, gs_eff};
  assign issue  = (s_r < end_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= 25'(num) * 25'(gs_eff);
    if (cmd.sinit) begin
      s_r     <= prod_r[12:0];
      end_r   <= (gend > {1'b0, tc_eff}) ? tc_eff : gend[12:0];
      cnt_r   <= '0;
      first_r <= '0;
      pend_r  <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) s_r <= s_r + 13'd1;
      pend_r   <= issue;
      pend_s_r <= s_r;
      if (pend_r && !rmap_rd_r) begin
        if (cnt_r == '0) first_r <= pend_s_r;
        cnt_r <= cnt_r + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + CLR_W'(1);
    end
  end

  assign map_raddr = cmd.scan ? CW'(s_r) : CW'(num);
  assign xaddr     = {(op_t'(it_r.operation) == OP_DATA) ? GW'(q_r) : gidx, WW'(w)};

  // execute step: result, store updates; the clear pass overrides the store writes
  always_comb begin
    logic sv, da_cur, pa_cur;
    sv        = 1'b0;
    da_cur    = da_r;
    pa_cur    = pa_r;
    res_nxt   = '0;
    rc_nxt    = rc_r;
    recc_nxt  = recc_r;
    map_we    = 1'b0;
    map_waddr = CW'(num);
    map_wd    = 1'b1;
    x_we      = 1'b0;
    x_waddr   = xaddr;
    x_wd      = xor_rd_r ^ it_r.word_value;
    ps_set    = 1'b0;
    unique case (op_t'(it_r.operation))
      OP_DATA: begin
        sv = ({1'b0, num} < tc_eff) && (32'(q_r) < MAX_GROUPS);
        if (w == '0) begin
          da_cur = sv && !rmap_rd_r && wok;
          if (da_cur) begin
            map_we = 1'b1;
            rc_nxt = rc_r + 13'd1;
          end
        end
        if (da_cur && sv && wok) begin
          x_we             = 1'b1;
          res_nxt.accepted = 1'b1;
        end
        if (it_r.last_word) da_cur = 1'b0;
      end
      OP_PARITY: begin
        if (w == '0) begin
          pa_cur = grp_ok && !ps_rd_r && wok;
          ps_set = pa_cur;
        end
        if (pa_cur && grp_ok && wok) begin
          x_we             = 1'b1;
          res_nxt.accepted = 1'b1;
        end
        if (it_r.last_word) pa_cur = 1'b0;
      end
      OP_CHECK: begin
        if (grp_ok) begin
          res_nxt.missing_chunks = cnt_r;
          if (cnt_r == 13'd1) begin
            res_nxt.missing_seq = first_r[11:0];
            if (ps_rd_r) begin
              map_we            = 1'b1;
              map_waddr         = CW'(first_r);
              rc_nxt            = rc_r + 13'd1;
              recc_nxt          = recc_r + 13'd1;
              res_nxt.recovered = 1'b1;
            end
          end
          res_nxt.accepted = (cnt_r == '0) || res_nxt.recovered;
        end
      end
      OP_READ: begin
        if (grp_in && w_in) begin
          res_nxt.read_value = xor_rd_r;
          res_nxt.accepted   = 1'b1;
        end
      end
    endcase
    da_nxt                  = da_cur;
    pa_nxt                  = pa_cur;
    res_nxt.received_total  = rc_nxt;
    res_nxt.recovered_total = recc_nxt;
    res_nxt.all_done        = (tc_eff != '0) && (rc_nxt >= tc_eff);
    map_we = map_we && cmd.exec;
    x_we   = x_we && cmd.exec;
    ps_set = ps_set && cmd.exec;
    if (cmd.clr) begin
      map_we    = 1'b1;
      map_waddr = CW'(clr_r);
      map_wd    = 1'b0;
      x_we      = 1'b1;
      x_waddr   = XW'(clr_r);
      x_wd      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) rmap[map_waddr] <= map_wd;
    rmap_rd_r <= rmap[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (x_we) xmem[x_waddr] <= x_wd;
    xor_rd_r <= xmem[xaddr];
  end

  // parity flags, cleared by the same pass as the other stores
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      ps_mem[GW'(clr_r)] <= 1'b0;
    end else if (ps_set) begin
      ps_mem[gidx] <= 1'b1;
    end
    ps_rd_r <= ps_mem[gidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      da_r   <= 1'b0;
      pa_r   <= 1'b0;
      rc_r   <= '0;
      recc_r <= '0;
    end else if (cmd.exec) begin
      da_r   <= da_nxt;
      pa_r   <= pa_nxt;
      rc_r   <= rc_nxt;
      recc_r <= recc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) res_r <= res_nxt;
  end

  assign res = res_r;

  assign sts.op        = op_t'(it_r.operation);
  assign sts.clr_done  = &clr_r;
  assign sts.hit       = cache_v_r && (cache_num_r == num);
  assign sts.div_done  = div_done;
  assign sts.grp_ok    = grp_ok;
  assign sts.scan_done = !issue && !pend_r;

  `XPCR_ASSERT_IMP(a_map_wr_src, map_we, cmd.exec || cmd.clr, "bitmap write outside execute or clear")
  `XPCR_ASSERT_IMP(a_rec_le_rcv, 1'b1, recc_r <= rc_r, "recovered count above received count")
  `XPCR_ASSERT_NEXT(a_div_cache, cmd.div && div_done, cache_v_r && (cache_num_r == $past(num)), "quotient cache not filled")

endmodule

// ===== rtl/core/xor_parity_chunk_recovery.sv =====
// XOR parity erasure recovery, receive side. Data and parity chunks arrive as
// 64-bit word transfers; each group keeps a XOR accumulator per word slot, a
// group check counts missing chunks and restores a single missing one when the
// group's parity has been seen, and read items return accumulator words.
// After reset the block runs a clearing pass over the chunk bitmap, the parity
// flags and the accumulator memory and stalls input meanwhile.
// Item steps from accept to next accept: a read looks up its accumulator word;
// a parity word first forms the group start; a data word runs a 12-step serial
// divide for the group number unless its sequence number matches the previous
// data word's; a group check forms the group bounds and then walks the bitmap
// one entry per cycle over the group's chunks (no walk for an invalid group).
// One result waits in the output register while the next item is taken.
// Configuration writes are expected only while idle.
module xor_parity_chunk_recovery
  import xpcr_pkg::*;
#(
  parameter int MAX_CHUNKS = 4096,
  parameter int MAX_GROUPS = 64,
  parameter int MAX_WORDS  = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // cap on the chunk count that a 13-bit register can express
  localparam int TC_CAP = (MAX_CHUNKS > 8191) ? 8191 : MAX_CHUNKS;

  logic [12:0] total_r, gsize_r;
  logic [10:0] cwords_r;
  logic [12:0] tc_eff, gs_eff;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        out_free;
  cmd_t        cmd;
  sts_t        sts;
  out_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= 13'd0;
      gsize_r  <= 13'd1;
      cwords_r <= 11'd1024;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_TOTAL)  total_r  <= cfg_wdata;
      if (cfg_addr == CFG_GSIZE)  gsize_r  <= cfg_wdata;
      if (cfg_addr == CFG_CWORDS) cwords_r <= cfg_wdata[10:0];
    end
  end

  // zero group size behaves as one
  assign tc_eff = (total_r > 13'(TC_CAP)) ? 13'(TC_CAP) : total_r;
  assign gs_eff = (gsize_r == '0) ? 13'd1 : gsize_r;

  // result slot frees when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  xpcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .out_free (out_free),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  xpcr_dp #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_WORDS  (MAX_WORDS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_item (in_data),
    .cfg_we  (cfg_we),
    .tc_eff  (tc_eff),
    .gs_eff  (gs_eff),
    .cwords  (cwords_r),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
